// ===== sv/cssa_pkg.sv =====
// Shared types, constants and tables of the CORDIC sine/cosine and atan2 unit.
// Depends on nothing; every other file of the unit imports it.
package cssa_pkg;

  // Default and legal range of the number of CORDIC steps.
  localparam int ITERATIONS_DEF = 25;
  localparam int ITER_MIN       = 8;
  localparam int ITER_MAX       = 28;

  // Field widths at the ports.
  localparam int ANGLE_IN_W  = 27;
  localparam int OPERAND_W   = 24;
  localparam int SINCOS_W    = 27;
  localparam int ANGLE_OUT_W = 28;

  // Width of the datapath words x, y and z inside the chain.
  localparam int DATA_W = 28;

  // Half a turn in angle units (2^25 per quarter turn).
  localparam logic signed [DATA_W-1:0] HALF_TURN = DATA_W'(64'sd67108864);
  localparam logic [DATA_W-1:0]        HALF_U    = DATA_W'(64'd67108864);
  localparam logic [DATA_W-1:0]        FULL_U    = DATA_W'(64'd134217728);

  // Operating modes.
  localparam logic MODE_SINCOS = 1'b0;
  localparam logic MODE_ATAN2  = 1'b1;

  // Word handed from one cell to the next. In sine/cosine mode quad holds the
  // quadrant of the input angle; in atan2 mode bit 0 marks a negative x and
  // bit 1 a negative y. In atan2 mode z holds minus the accumulated angle.
  typedef struct packed {
    logic                     mode;
    logic [1:0]               quad;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } stage_t;

  // Quadrant codes of the sine/cosine fold.
  localparam logic [1:0] QUAD_1 = 2'd0;
  localparam logic [1:0] QUAD_2 = 2'd1;
  localparam logic [1:0] QUAD_3 = 2'd2;
  localparam logic [1:0] QUAD_4 = 2'd3;

  // Sign codes of the atan2 fold: bit 1 set for a negative y, bit 0 for a
  // negative x.
  localparam logic [1:0] VEC_Q1 = 2'b00;
  localparam logic [1:0] VEC_Q2 = 2'b01;
  localparam logic [1:0] VEC_Q3 = 2'b11;
  localparam logic [1:0] VEC_Q4 = 2'b10;

  // Step count actually used, clamped to ITER_MIN..ITER_MAX.
  function automatic int clamp_steps(input int n);
    int r;
    r = n;
    if (r < ITER_MIN) r = ITER_MIN;
    if (r > ITER_MAX) r = ITER_MAX;
    return r;
  endfunction

  // Rounded arctangent of 2^-i, scaled to 2^25 units per quarter turn.
  function automatic logic signed [DATA_W-1:0] atan_entry(input int i);
    logic signed [DATA_W-1:0] r;
    unique case (i)
      0:       r = DATA_W'(64'sd16777216);
      1:       r = DATA_W'(64'sd9904169);
      2:       r = DATA_W'(64'sd5233091);
      3:       r = DATA_W'(64'sd2656399);
      4:       r = DATA_W'(64'sd1333354);
      5:       r = DATA_W'(64'sd667327);
      6:       r = DATA_W'(64'sd333745);
      7:       r = DATA_W'(64'sd166883);
      8:       r = DATA_W'(64'sd83443);
      9:       r = DATA_W'(64'sd41721);
      10:      r = DATA_W'(64'sd20861);
      11:      r = DATA_W'(64'sd10430);
      12:      r = DATA_W'(64'sd5215);
      13:      r = DATA_W'(64'sd2608);
      14:      r = DATA_W'(64'sd1304);
      15:      r = DATA_W'(64'sd652);
      16:      r = DATA_W'(64'sd326);
      17:      r = DATA_W'(64'sd163);
      18:      r = DATA_W'(64'sd81);
      19:      r = DATA_W'(64'sd41);
      20:      r = DATA_W'(64'sd20);
      21:      r = DATA_W'(64'sd10);
      22:      r = DATA_W'(64'sd5);
      23:      r = DATA_W'(64'sd3);
      24:      r = DATA_W'(64'sd1);
      25:      r = DATA_W'(64'sd1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Rounded inverse CORDIC gain for a given step count, scaled by 2^25.
  function automatic logic signed [DATA_W-1:0] gain_for(input int n);
    logic signed [DATA_W-1:0] r;
    unique case (n)
      8:       r = DATA_W'(64'sd20376235);
      9:       r = DATA_W'(64'sd20376079);
      10:      r = DATA_W'(64'sd20376040);
      11:      r = DATA_W'(64'sd20376031);
      12:      r = DATA_W'(64'sd20376028);
      13:      r = DATA_W'(64'sd20376028);
      default: r = DATA_W'(64'sd20376027);
    endcase
    return r;
  endfunction

endpackage

// ===== sv/cssa_fold.sv =====
// Entry stage: folds the angle or the (x, y) vector into the first quadrant.
// Depends on cssa_pkg.
module cssa_fold
  import cssa_pkg::*;
#(
  parameter int STEPS = ITERATIONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         valid_in,
  input  logic                         mode,
  input  logic [ANGLE_IN_W-1:0]        angle_in,
  input  logic signed [OPERAND_W-1:0]  x_in,
  input  logic signed [OPERAND_W-1:0]  y_in,
  output logic                         valid_r,
  output stage_t                       q_r
);

  logic [DATA_W-1:0]        th;
  logic [DATA_W-1:0]        z_mag;
  logic signed [DATA_W-1:0] xe;
  logic signed [DATA_W-1:0] ye;
  stage_t                   q_nxt;

  // Quadrant fold of the angle and sign fold of the vector.
  always_comb begin
    th    = DATA_W'(angle_in);
    xe    = DATA_W'(x_in);
    ye    = DATA_W'(y_in);
    z_mag = th;
    q_nxt = '0;
    q_nxt.mode = mode;
    if (mode == MODE_SINCOS) begin
      unique case (angle_in[ANGLE_IN_W-1 -: 2])
        QUAD_1:  z_mag = th;
        QUAD_2:  z_mag = HALF_U - th;
        QUAD_3:  z_mag = th - HALF_U;
        default: z_mag = FULL_U - th;
      endcase
      q_nxt.quad = angle_in[ANGLE_IN_W-1 -: 2];
      q_nxt.x    = gain_for(STEPS);
      q_nxt.y    = '0;
      q_nxt.z    = -$signed(z_mag);
    end else begin
      q_nxt.quad = {ye[DATA_W-1], xe[DATA_W-1]};
      q_nxt.x    = xe[DATA_W-1] ? -xe : xe;
      q_nxt.y    = ye[DATA_W-1] ? -ye : ye;
      q_nxt.z    = '0;
    end
  end

  // Stage registers: valid is reset, the payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ===== sv/cssa_cell.sv =====
// One CORDIC micro-rotation cell: a shift-add step on x, y and z.
// Depends on cssa_pkg.
module cssa_cell
  import cssa_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   valid_in,
  input  stage_t d,
  output logic   valid_r,
  output stage_t q_r
);

  localparam logic signed [DATA_W-1:0] ATAN_K = atan_entry(SHIFT);

  logic                     dir_neg;
  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  stage_t                   q_nxt;

  // Rotation follows the sign of z; vectoring drives y towards zero, with z
  // accumulating the negated angle so both modes share one update.
  always_comb begin
    dir_neg = (d.mode == MODE_ATAN2) ? !(d.y > 0) : d.z[DATA_W-1];
    xs      = d.x >>> SHIFT;
    ys      = d.y >>> SHIFT;
    q_nxt   = d;
    if (dir_neg) begin
      q_nxt.x = d.x - ys;
      q_nxt.y = d.y + xs;
      q_nxt.z = d.z + ATAN_K;
    end else begin
      q_nxt.x = d.x + ys;
      q_nxt.y = d.y - xs;
      q_nxt.z = d.z - ATAN_K;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ===== sv/cssa_post.sv =====
// Exit stage: quadrant correction of the results and the output register.
// Depends on cssa_pkg.
module cssa_post
  import cssa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_in,
  input  stage_t                        d,
  output logic                          valid_r,
  output logic signed [SINCOS_W-1:0]    sine_r,
  output logic signed [SINCOS_W-1:0]    cosine_r,
  output logic signed [ANGLE_OUT_W-1:0] angle_r
);

  logic signed [DATA_W-1:0]      s_full;
  logic signed [DATA_W-1:0]      c_full;
  logic signed [SINCOS_W-1:0]    sine_nxt;
  logic signed [SINCOS_W-1:0]    cosine_nxt;
  logic signed [ANGLE_OUT_W-1:0] angle_nxt;

  // Sign correction per quadrant; the vector angle is rebuilt from -z.
  always_comb begin
    s_full     = '0;
    c_full     = '0;
    angle_nxt  = '0;
    if (d.mode == MODE_SINCOS) begin
      c_full = ((d.quad == QUAD_1) || (d.quad == QUAD_4)) ? d.x : -d.x;
      s_full = ((d.quad == QUAD_1) || (d.quad == QUAD_2)) ? d.y : -d.y;
    end else begin
      unique case (d.quad)
        VEC_Q1:  angle_nxt = ANGLE_OUT_W'(-d.z);
        VEC_Q2:  angle_nxt = ANGLE_OUT_W'(HALF_TURN + d.z);
        VEC_Q3:  angle_nxt = ANGLE_OUT_W'(-d.z - HALF_TURN);
        default: angle_nxt = ANGLE_OUT_W'(d.z);
      endcase
    end
    sine_nxt   = s_full[SINCOS_W-1:0];
    cosine_nxt = c_full[SINCOS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine_r   <= sine_nxt;
      cosine_r <= cosine_nxt;
      angle_r  <= angle_nxt;
    end
  end

endmodule

// ===== sv/cordic_sincos_atan2_unit.sv =====
// CORDIC sine/cosine and atan2 unit: fold stage, a row of shift-add cells and
// an exit stage. STEPS, the number of cells, is ITERATIONS clamped to 8..28.
// Throughput is one transfer per cycle; the chain holds only while a finished
// result waits at the output, and in_stall then follows out_stall. Synchronous
// active-low reset empties the chain; payload registers keep their contents.
// Depends on cssa_pkg, cssa_fold, cssa_cell and cssa_post.
module cordic_sincos_atan2_unit
  import cssa_pkg::*;
#(
  parameter int ITERATIONS = ITERATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [ANGLE_IN_W-1:0]         in_angle_in,
  input  logic signed [OPERAND_W-1:0]   in_x_in,
  input  logic signed [OPERAND_W-1:0]   in_y_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SINCOS_W-1:0]    out_sine,
  output logic signed [SINCOS_W-1:0]    out_cosine,
  output logic signed [ANGLE_OUT_W-1:0] out_angle_out
);

  localparam int STEPS = clamp_steps(ITERATIONS);

  logic   en;
  logic   vld [STEPS+1];
  stage_t stg [STEPS+1];

  // The chain advances unless a finished result is held at the output.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  cssa_fold #(
    .STEPS (STEPS)
  ) u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (in_valid),
    .mode     (in_mode),
    .angle_in (in_angle_in),
    .x_in     (in_x_in),
    .y_in     (in_y_in),
    .valid_r  (vld[0]),
    .q_r      (stg[0])
  );

  // Row of micro-rotation cells, one per CORDIC step.
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    cssa_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (vld[i]),
      .d        (stg[i]),
      .valid_r  (vld[i+1]),
      .q_r      (stg[i+1])
    );
  end

  cssa_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (vld[STEPS]),
    .d        (stg[STEPS]),
    .valid_r  (out_valid),
    .sine_r   (out_sine),
    .cosine_r (out_cosine),
    .angle_r  (out_angle_out)
  );

endmodule

// ===== sv/cssa_checker.sv =====
// Port-level checks of the CORDIC unit, bound to its top level.
// Depends on cssa_pkg and cordic_sincos_atan2_unit.
module cssa_checker
  import cssa_pkg::*;
(
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SINCOS_W-1:0]    out_sine,
  input logic signed [SINCOS_W-1:0]    out_cosine,
  input logic signed [ANGLE_OUT_W-1:0] out_angle_out
);

  // A held result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sine) &&
      $stable(out_cosine) && $stable(out_angle_out))
    else $error("held result changed");

  // The input side stalls only behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A result carries either sine/cosine or an angle, never both.
  a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_out == '0) || ((out_sine == '0) && (out_cosine == '0)))
    else $error("result mixes both modes");

  // Reset empties the chain.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cordic_sincos_atan2_unit cssa_checker u_cssa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_sine      (out_sine),
  .out_cosine    (out_cosine),
  .out_angle_out (out_angle_out)
);

// ===== tb/tb_cordic_sincos_atan2_unit.sv =====
// Self-checking testbench for the CORDIC sine/cosine and atan2 unit.
// A predictor of its own computes each result. Depends on cssa_pkg and
// cordic_sincos_atan2_unit.
module tb_cordic_sincos_atan2_unit;
  import cssa_pkg::*;

  // Step count of the instance and the count that the unit really uses.
  localparam int STEPS      = ITERATIONS_DEF;
  localparam int STEPS_USED = (STEPS < ITER_MIN) ? ITER_MIN :
                              (STEPS > ITER_MAX) ? ITER_MAX : STEPS;
  localparam longint QTR    = 64'sd33554432;
  localparam int LATENCY    = STEPS_USED + 2;
  localparam int LONG_HOLD  = 200;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [SINCOS_W-1:0]    sine;
    logic signed [SINCOS_W-1:0]    cosine;
    logic signed [ANGLE_OUT_W-1:0] angle_out;
  } trig_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = MODE_SINCOS;
  logic [ANGLE_IN_W-1:0] in_angle_in = '0;
  logic signed [OPERAND_W-1:0] in_x_in = '0;
  logic signed [OPERAND_W-1:0] in_y_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SINCOS_W-1:0] out_sine;
  logic signed [SINCOS_W-1:0] out_cosine;
  logic signed [ANGLE_OUT_W-1:0] out_angle_out;

  trig_result_t awaited_results[$];
  int error_count = 0;
  int checked_count = 0;
  int sincos_sent = 0;
  int atan2_sent = 0;
  int cycle_count = 0;
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  bit long_hold_req = 1'b0;

  cordic_sincos_atan2_unit #(.ITERATIONS(STEPS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_angle_in  (in_angle_in),
    .in_x_in      (in_x_in),
    .in_y_in      (in_y_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sine     (out_sine),
    .out_cosine   (out_cosine),
    .out_angle_out(out_angle_out)
  );

  // Clock with a period of four time units.
  initial begin
    forever #2 clk = ~clk;
  end

  // Arctangent of 2^-i in angle units, rounded.
  function automatic longint arctan_lut(input int i);
    case (i)
      0:  return 16777216;
      1:  return 9904169;
      2:  return 5233091;
      3:  return 2656399;
      4:  return 1333354;
      5:  return 667327;
      6:  return 333745;
      7:  return 166883;
      8:  return 83443;
      9:  return 41721;
      10: return 20861;
      11: return 10430;
      12: return 5215;
      13: return 2608;
      14: return 1304;
      15: return 652;
      16: return 326;
      17: return 163;
      18: return 81;
      19: return 41;
      20: return 20;
      21: return 10;
      22: return 5;
      23: return 3;
      24: return 1;
      25: return 1;
      default: return 0;
    endcase
  endfunction

  // Starting x of the rotation: the inverse gain for n steps.
  function automatic longint start_gain(input int n);
    case (n)
      8:  return 20376235;
      9:  return 20376079;
      10: return 20376040;
      11: return 20376031;
      12: return 20376028;
      13: return 20376028;
      default: return 20376027;
    endcase
  endfunction

  // Expected sine, cosine and atan2 of one input item.
  function automatic trig_result_t predict_trig(input logic mode,
                                                input logic [ANGLE_IN_W-1:0] ang,
                                                input logic signed [OPERAND_W-1:0] xo,
                                                input logic signed [OPERAND_W-1:0] yo);
    trig_result_t r;
    longint th, z, x, y, nx, ny, sum, a;
    logic [1:0] quad;
    bit xp, yp;
    int i;
    r = '0;
    if (mode == MODE_SINCOS) begin
      // Fold the angle into the first quadrant.
      th = longint'(ang);
      if (th < QTR) begin
        quad = QUAD_1;
        z = th;
      end else if (th < 2 * QTR) begin
        quad = QUAD_2;
        z = 2 * QTR - th;
      end else if (th < 3 * QTR) begin
        quad = QUAD_3;
        z = th - 2 * QTR;
      end else begin
        quad = QUAD_4;
        z = 4 * QTR - th;
      end
      x = start_gain(STEPS_USED);
      y = 0;
      z = -z;
      // Rotation steps with flooring shifts.
      for (i = 0; i < STEPS_USED; i++) begin
        if (z < 0) begin
          z += arctan_lut(i);
          ny = y + (x >>> i);
          nx = x - (y >>> i);
        end else begin
          z -= arctan_lut(i);
          ny = y - (x >>> i);
          nx = x + (y >>> i);
        end
        x = nx;
        y = ny;
      end
      if (quad == QUAD_2 || quad == QUAD_3) x = -x;
      if (quad == QUAD_3 || quad == QUAD_4) y = -y;
      r.sine   = y[SINCOS_W-1:0];
      r.cosine = x[SINCOS_W-1:0];
    end else begin
      // Fold the vector, a zero operand counting as positive.
      x = longint'(xo);
      y = longint'(yo);
      xp = (x >= 0);
      yp = (y >= 0);
      if (!xp) x = -x;
      if (!yp) y = -y;
      sum = 0;
      for (i = 0; i < STEPS_USED; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          sum += arctan_lut(i);
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          sum -= arctan_lut(i);
        end
        x = nx;
        y = ny;
      end
      if (xp && yp) a = sum;
      else if (!xp && yp) a = 2 * QTR - sum;
      else if (!xp && !yp) a = sum - 2 * QTR;
      else a = -sum;
      r.angle_out = a[ANGLE_OUT_W-1:0];
    end
    return r;
  endfunction

  // Operand biased towards small values, extremes and powers of two.
  function automatic logic signed [OPERAND_W-1:0] pick_operand();
    logic signed [OPERAND_W-1:0] v;
    case ($urandom_range(0, 5))
      1: v = OPERAND_W'(int'($urandom_range(0, 511)) - 256);
      2: begin
        case ($urandom_range(0, 4))
          0: v = {1'b1, {(OPERAND_W-1){1'b0}}};
          1: v = {1'b0, {(OPERAND_W-1){1'b1}}};
          2: v = '0;
          3: v = OPERAND_W'(1);
          default: v = '1;
        endcase
      end
      3: begin
        v = OPERAND_W'(1) << $urandom_range(0, OPERAND_W - 2);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = OPERAND_W'($urandom);
    endcase
    return v;
  endfunction

  // Angle biased towards the quadrant boundaries and small values.
  function automatic logic [ANGLE_IN_W-1:0] pick_angle();
    logic [ANGLE_IN_W-1:0] v;
    case ($urandom_range(0, 3))
      1: v = ANGLE_IN_W'(longint'($urandom_range(0, 3)) * QTR
                         + longint'($urandom_range(0, 6)) - 3);
      2: v = ANGLE_IN_W'($urandom_range(0, 1023));
      default: v = ANGLE_IN_W'($urandom);
    endcase
    return v;
  endfunction

  // Offer one item, with an optional gap first, and wait for its transfer.
  task automatic send_item(input logic mode, input logic [ANGLE_IN_W-1:0] ang,
                           input logic signed [OPERAND_W-1:0] xo,
                           input logic signed [OPERAND_W-1:0] yo);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_angle_in <= ang;
    in_x_in     <= xo;
    in_y_in     <= yo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(predict_trig(mode, ang, xo, yo));
    if (mode == MODE_SINCOS) sincos_sent++;
    else atan2_sent++;
  endtask

  // Lower valid after the last transfer of a phase.
  task automatic pause_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sincos(input longint ang);
    send_item(MODE_SINCOS, ANGLE_IN_W'(ang), pick_operand(), pick_operand());
  endtask

  task automatic send_atan2(input longint xo, input longint yo);
    send_item(MODE_ATAN2, pick_angle(), OPERAND_W'(xo), OPERAND_W'(yo));
  endtask

  // Angles at zero, at each quadrant boundary and at the top of the range.
  task automatic test_sincos_boundaries();
    send_sincos(0);
    send_sincos(1);
    send_sincos(QTR - 1);
    send_sincos(QTR);
    send_sincos(QTR + 1);
    send_sincos(2 * QTR - 1);
    send_sincos(2 * QTR);
    send_sincos(2 * QTR + 1);
    send_sincos(3 * QTR - 1);
    send_sincos(3 * QTR);
    send_sincos(3 * QTR + 1);
    send_sincos(4 * QTR - 1);
    send_sincos(QTR / 2);
    send_sincos(64'h5555555);
    pause_sender();
  endtask

  // Zero operands, both operands zero, most negative and largest operands.
  task automatic test_atan2_special();
    send_atan2(0, 0);
    send_atan2(0, 256);
    send_atan2(256, 0);
    send_atan2(-256, 0);
    send_atan2(0, -256);
    send_atan2(-8388608, -8388608);
    send_atan2(8388607, 8388607);
    send_atan2(-8388608, 8388607);
    send_atan2(8388607, -8388608);
    send_atan2(1, 1);
    send_atan2(-1, -1);
    pause_sender();
  endtask

  // Random items of both modes, with idling as tx_idling and rx_idling allow.
  task automatic test_random_mixed(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 1) == 0)
        send_item(MODE_SINCOS, pick_angle(), pick_operand(), pick_operand());
      else
        send_item(MODE_ATAN2, pick_angle(), pick_operand(), pick_operand());
    end
    pause_sender();
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_hold(input int count);
    tx_idling = 1'b0;
    long_hold_req = 1'b1;
    test_random_mixed(count);
    tx_idling = 1'b1;
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_full_rate(input int count);
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    test_random_mixed(count);
  endtask

  // Receiver pacing: random stall bursts, or one long hold on request.
  initial begin
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (rx_idling && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    trig_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result sine=%0d cosine=%0d angle=%0d", $time,
                 out_sine, out_cosine, out_angle_out);
        error_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        checked_count++;
        if (out_sine !== exp_r.sine) begin
          $display("%0t: sine expected %0d actual %0d", $time, exp_r.sine, out_sine);
          error_count++;
        end
        if (out_cosine !== exp_r.cosine) begin
          $display("%0t: cosine expected %0d actual %0d", $time, exp_r.cosine,
                   out_cosine);
          error_count++;
        end
        if (out_angle_out !== exp_r.angle_out) begin
          $display("%0t: angle_out expected %0d actual %0d", $time, exp_r.angle_out,
                   out_angle_out);
          error_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", awaited_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Reset, the test sequence, the drain and the verdict.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sincos_boundaries();
    test_atan2_special();
    test_random_mixed(1300);
    test_output_hold(100);
    test_full_rate(225);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d results: %0d sine/cosine items and %0d atan2 items,",
             checked_count, sincos_sent, atan2_sent);
    $display("including boundary angles, zero and extreme operands and a long output hold.");
    if (awaited_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
